### design/ket_pkg.sv
// ----------------------------------------------------------------------------
// Key edge tracker package
// Shared types, constants and the key-code decoder for the key edge tracker
// with smoothed axes.
// ----------------------------------------------------------------------------
package ket_pkg;

	// Defaults for the top-level parameters
	localparam int NUM_KEYS_DEF = 63;
	localparam int NUM_AXES_DEF = 4;

	// Axes with a fixed key pair
	localparam int AXIS_TBL = 4;

	// Register file
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_THR  = 1'b1;
	localparam logic [7:0]  GAIN_RST = 8'd26;
	localparam logic [14:0] THR_RST  = 15'd164;

	// Q1.14 full scale
	localparam logic signed [15:0] LEVEL_POS = 16'sd16384;
	localparam logic signed [15:0] LEVEL_NEG = -16'sd16384;

	// Smoothing datapath widths
	localparam int DIFF_W = 17;
	localparam int PROD_W = 26;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = 26'sd128;

	// Key phases
	typedef enum logic [1:0] {
		PH_NONE     = 2'd0,
		PH_PRESSED  = 2'd1,
		PH_HELD     = 2'd2,
		PH_RELEASED = 2'd3
	} phase_t;

	// Dense key codes
	localparam logic [7:0] KEY_UP     = 8'd0;
	localparam logic [7:0] KEY_DOWN   = 8'd1;
	localparam logic [7:0] KEY_LEFT   = 8'd2;
	localparam logic [7:0] KEY_RIGHT  = 8'd3;
	localparam logic [7:0] KEY_F1     = 8'd4;
	localparam logic [7:0] KEY_F11    = 8'd14;
	localparam logic [7:0] KEY_F12    = 8'd15;
	localparam logic [7:0] KEY_INS    = 8'd16;
	localparam logic [7:0] KEY_DEL    = 8'd17;
	localparam logic [7:0] KEY_HOME   = 8'd18;
	localparam logic [7:0] KEY_END    = 8'd19;
	localparam logic [7:0] KEY_PGUP   = 8'd20;
	localparam logic [7:0] KEY_PGDN   = 8'd21;
	localparam logic [7:0] KEY_ESC    = 8'd22;
	localparam logic [7:0] KEY_ENTER  = 8'd23;
	localparam logic [7:0] KEY_SPACE  = 8'd24;
	localparam logic [7:0] KEY_BKSP   = 8'd25;
	localparam logic [7:0] KEY_TAB    = 8'd26;
	localparam logic [7:0] KEY_DIGIT0 = 8'd27;
	localparam logic [7:0] KEY_A      = 8'd37;
	localparam logic [7:0] KEY_D      = 8'd40;
	localparam logic [7:0] KEY_S      = 8'd55;
	localparam logic [7:0] KEY_W      = 8'd59;
	localparam logic [7:0] NO_KEY     = 8'd255;

	// Extended scan codes
	localparam logic [7:0] EXT_F1   = 8'd59;
	localparam logic [7:0] EXT_F10  = 8'd68;
	localparam logic [7:0] EXT_UP   = 8'd72;
	localparam logic [7:0] EXT_DOWN = 8'd80;
	localparam logic [7:0] EXT_LEFT = 8'd75;
	localparam logic [7:0] EXT_RGHT = 8'd77;
	localparam logic [7:0] EXT_F11  = 8'd133;
	localparam logic [7:0] EXT_F12  = 8'd134;
	localparam logic [7:0] EXT_INS  = 8'd82;
	localparam logic [7:0] EXT_DEL  = 8'd83;
	localparam logic [7:0] EXT_HOME = 8'd71;
	localparam logic [7:0] EXT_END  = 8'd79;
	localparam logic [7:0] EXT_PGUP = 8'd73;
	localparam logic [7:0] EXT_PGDN = 8'd81;

	// Raw character bytes
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_ENTER = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_BKSP  = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UP_A  = 8'd65;
	localparam logic [7:0] CH_UP_Z  = 8'd90;
	localparam logic [7:0] CH_LO_A  = 8'd97;
	localparam logic [7:0] CH_LO_Z  = 8'd122;

	// Axis key pairs: right/left, up/down, D/A, W/S
	localparam logic [7:0] AXIS_POS_KEY [AXIS_TBL] = '{KEY_RIGHT, KEY_UP, KEY_D, KEY_W};
	localparam logic [7:0] AXIS_NEG_KEY [AXIS_TBL] = '{KEY_LEFT, KEY_DOWN, KEY_A, KEY_S};

	// Translate a report into a dense key code, NO_KEY when unknown
	function automatic logic [7:0] decode_key(input logic [7:0] ch, input logic [7:0] ext);
		logic [7:0] code;
		code = NO_KEY;
		if (ext != 8'd0) begin
			unique case (ext) inside
				[EXT_F1:EXT_F10]: code = ext - EXT_F1 + KEY_F1;
				EXT_UP:           code = KEY_UP;
				EXT_DOWN:         code = KEY_DOWN;
				EXT_LEFT:         code = KEY_LEFT;
				EXT_RGHT:         code = KEY_RIGHT;
				EXT_F11:          code = KEY_F11;
				EXT_F12:          code = KEY_F12;
				EXT_INS:          code = KEY_INS;
				EXT_DEL:          code = KEY_DEL;
				EXT_HOME:         code = KEY_HOME;
				EXT_END:          code = KEY_END;
				EXT_PGUP:         code = KEY_PGUP;
				EXT_PGDN:         code = KEY_PGDN;
				default:          code = NO_KEY;
			endcase
		end else begin
			unique case (ch) inside
				[CH_ZERO:CH_NINE]: code = ch - CH_ZERO + KEY_DIGIT0;
				[CH_UP_A:CH_UP_Z]: code = ch - CH_UP_A + KEY_A;
				[CH_LO_A:CH_LO_Z]: code = ch - CH_LO_A + KEY_A;
				CH_ESC:            code = KEY_ESC;
				CH_ENTER:          code = KEY_ENTER;
				CH_SPACE:          code = KEY_SPACE;
				CH_BKSP:           code = KEY_BKSP;
				CH_TAB:            code = KEY_TAB;
				default:           code = NO_KEY;
			endcase
		end
		return code;
	endfunction

	// Age a key phase, then apply what the frame saw
	function automatic phase_t next_phase(input phase_t ph, input logic seen, input logic phys);
		phase_t aged;
		phase_t nxt;
		case (ph)
			PH_PRESSED:  aged = PH_HELD;
			PH_RELEASED: aged = PH_NONE;
			default:     aged = ph;
		endcase
		if (seen) begin
			nxt = (aged == PH_NONE) ? PH_PRESSED : PH_HELD;
		end else if (aged == PH_HELD && !phys) begin
			nxt = PH_RELEASED;
		end else begin
			nxt = aged;
		end
		return nxt;
	endfunction

endpackage

### design/ket_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ket_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### design/ket_axis_smoother.sv
// ----------------------------------------------------------------------------
// Axis smoother
// Walks the axes one per cycle through a three-stage read, multiply and
// write-back pipeline around the axis level RAM.
// ----------------------------------------------------------------------------
module ket_axis_smoother #(
	parameter int NUM_KEYS = ket_pkg::NUM_KEYS_DEF,
	parameter int NUM_AXES = ket_pkg::NUM_AXES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_KEYS-1:0] key_down,
	input  logic [7:0]          gain,
	input  logic [14:0]         threshold,
	output logic                done,
	output logic signed [15:0]  axis_lvl [ket_pkg::AXIS_TBL]
);
	localparam int NA = (NUM_AXES < ket_pkg::AXIS_TBL) ? NUM_AXES : ket_pkg::AXIS_TBL;
	localparam int IW = (NA > 1) ? $clog2(NA) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NA - 1);

	logic          rd_act_q;
	logic [IW-1:0] rd_idx_q;
	logic [15:0]   rd_data;

	logic          v_s1;
	logic [IW-1:0] idx_s1;

	logic                                 v_s2;
	logic [IW-1:0]                        idx_s2;
	logic signed [ket_pkg::PROD_W-1:0]    prod_s2;
	logic signed [15:0]                   level_s2;
	logic signed [15:0]                   target_s2;
	logic                                 snap_s2;

	logic              vld_q [NA];
	logic signed [15:0] lvl_q [NA];

	// Stage 1 signals
	logic [7:0]                        pos_key;
	logic [7:0]                        neg_key;
	logic                              pos_dn;
	logic                              neg_dn;
	logic signed [15:0]                cur_lvl;
	logic signed [15:0]                target;
	logic signed [ket_pkg::DIFF_W-1:0] diff;
	logic [ket_pkg::DIFF_W-1:0]        mag;
	logic                              snap;

	// Stage 2 signals
	logic signed [ket_pkg::PROD_W-1:0] rounded;
	logic signed [17:0]                step;
	logic signed [17:0]                sum;
	logic signed [15:0]                new_lvl;

	// Issue one axis read per cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q <= 1'b0;
			rd_idx_q <= '0;
		end else if (start) begin
			rd_act_q <= 1'b1;
			rd_idx_q <= '0;
		end else if (rd_act_q) begin
			rd_idx_q <= rd_idx_q + 1'b1;
			if (rd_idx_q == LAST_IDX) begin
				rd_act_q <= 1'b0;
			end
		end
	end

	ket_ram #(
		.WIDTH (16),
		.DEPTH (NA)
	) u_level_ram (
		.clk   (clk),
		.we    (v_s2),
		.waddr (idx_s2),
		.wdata (new_lvl),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	// Stage 1: current level, target and distance
	always_comb begin
		pos_key = ket_pkg::AXIS_POS_KEY[2'(idx_s1)];
		neg_key = ket_pkg::AXIS_NEG_KEY[2'(idx_s1)];
		pos_dn  = 1'b0;
		neg_dn  = 1'b0;
		for (int j = 0; j < NUM_KEYS; j++) begin
			if (pos_key == 8'(j)) pos_dn = key_down[j];
			if (neg_key == 8'(j)) neg_dn = key_down[j];
		end
		if (pos_dn && !neg_dn) begin
			target = ket_pkg::LEVEL_POS;
		end else if (neg_dn && !pos_dn) begin
			target = ket_pkg::LEVEL_NEG;
		end else begin
			target = '0;
		end
		cur_lvl = vld_q[idx_s1] ? $signed(rd_data) : 16'sd0;
		diff    = $signed({target[15], target}) - $signed({cur_lvl[15], cur_lvl});
		mag     = diff[ket_pkg::DIFF_W-1] ? ket_pkg::DIFF_W'(-diff) : ket_pkg::DIFF_W'(diff);
		snap    = (gain == 8'd0) || (mag < {2'b00, threshold});
	end

	// Pipeline registers: stage 1 to stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_act_q;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= rd_idx_q;
		idx_s2    <= idx_s1;
		prod_s2   <= diff * $signed({1'b0, gain});
		level_s2  <= cur_lvl;
		target_s2 <= target;
		snap_s2   <= snap;
	end

	// Stage 2: round the step, snap, write back
	always_comb begin
		rounded = prod_s2 + ket_pkg::ROUND_HALF;
		step    = rounded[ket_pkg::PROD_W-1:8];
		sum     = $signed({{2{level_s2[15]}}, level_s2}) + step;
		new_lvl = snap_s2 ? target_s2 : sum[15:0];
	end

	assign done = v_s2 && (idx_s2 == LAST_IDX);

	// Track written entries; an unwritten axis reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NA; a++) vld_q[a] <= 1'b0;
		end else if (v_s2) begin
			vld_q[idx_s2] <= 1'b1;
		end
	end

	// Hold the published levels
	always_ff @(posedge clk) begin
		if (v_s2) begin
			lvl_q[idx_s2] <= new_lvl;
		end
	end

	for (genvar a = 0; a < ket_pkg::AXIS_TBL; a++) begin : g_out
		if (a < NA) begin : g_live
			assign axis_lvl[a] = lvl_q[a];
		end else begin : g_zero
			assign axis_lvl[a] = '0;
		end
	end

endmodule

### design/key_edge_tracker_axis_smoother_top.sv
// ----------------------------------------------------------------------------
// Key edge tracker with smoothed axes
// Tracks key phases from key reports and poll ticks and smooths up to four axes.
// ----------------------------------------------------------------------------
// A key report gives no result; reports are taken back to back, also while a
// poll result waits or while the axes update. A poll ages every key phase in
// the cycle it is taken, then walks the axes through the level RAM one per
// cycle in a three-stage pipeline. A new poll is held off until the previous
// result is taken and the axis walk is finished.
// Registers: offset 0 smoothing gain (8 bits, reset 26), offset 4 snap
// threshold (15 bits, reset 164); address bits [1:0] are ignored.
module key_edge_tracker_axis_smoother_top #(
	parameter int NUM_KEYS = ket_pkg::NUM_KEYS_DEF,
	parameter int NUM_AXES = ket_pkg::NUM_AXES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ket_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ket_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ket_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	// Input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [7:0]                        raw_char,
	input  logic [7:0]                        extended_code,
	input  logic [NUM_KEYS-1:0]               physically_down_mask,
	// Result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [NUM_KEYS-1:0]               newly_pressed_mask,
	output logic [NUM_KEYS-1:0]               newly_released_mask,
	output logic [NUM_KEYS-1:0]               down_mask,
	output logic                              any_down,
	output logic signed [15:0]                axis_horizontal,
	output logic signed [15:0]                axis_vertical,
	output logic signed [15:0]                axis_horizontal_letters,
	output logic signed [15:0]                axis_vertical_letters
);
	logic [7:0]  gain_q;
	logic [14:0] thr_q;

	ket_pkg::phase_t phase_q [NUM_KEYS];
	ket_pkg::phase_t phase_nxt [NUM_KEYS];
	logic [NUM_KEYS-1:0] seen_q;
	logic [NUM_KEYS-1:0] key_down;

	logic                busy_q;
	logic                out_valid_q;
	logic [NUM_KEYS-1:0] pressed_q;
	logic [NUM_KEYS-1:0] released_q;
	logic [NUM_KEYS-1:0] down_q;
	logic                any_down_q;

	logic                in_acc;
	logic                poll_acc;
	logic                rep_acc;
	logic [7:0]          key_code;
	logic                cfg_wr;
	logic                axis_done;
	logic signed [15:0]  axis_lvl [ket_pkg::AXIS_TBL];

	logic [NUM_KEYS-1:0] pressed_nxt;
	logic [NUM_KEYS-1:0] released_nxt;
	logic [NUM_KEYS-1:0] down_nxt;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ket_pkg::GAIN_RST;
			thr_q  <= ket_pkg::THR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ket_pkg::REG_GAIN: gain_q <= pwdata[7:0];
				ket_pkg::REG_THR:  thr_q  <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ket_pkg::REG_GAIN: prdata = {24'd0, gain_q};
			ket_pkg::REG_THR:  prdata = {17'd0, thr_q};
			default:           prdata = '0;
		endcase
	end

	// Input handshake: a poll waits for the axis walk and the result slot
	assign in_stall = action && (busy_q || out_valid_q);
	assign in_acc   = in_valid && !in_stall;
	assign poll_acc = in_acc && action;
	assign rep_acc  = in_acc && !action;
	assign key_code = ket_pkg::decode_key(raw_char, extended_code);

	// Next key phases and masks for a poll
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			phase_nxt[k]    = ket_pkg::next_phase(phase_q[k], seen_q[k], physically_down_mask[k]);
			pressed_nxt[k]  = (phase_nxt[k] == ket_pkg::PH_PRESSED);
			released_nxt[k] = (phase_nxt[k] == ket_pkg::PH_RELEASED);
			down_nxt[k]     = (phase_nxt[k] == ket_pkg::PH_PRESSED) ||
			                  (phase_nxt[k] == ket_pkg::PH_HELD);
			key_down[k]     = (phase_q[k] == ket_pkg::PH_PRESSED) ||
			                  (phase_q[k] == ket_pkg::PH_HELD);
		end
	end

	// Key state: mark seen keys on a report, advance phases on a poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) phase_q[k] <= ket_pkg::PH_NONE;
			seen_q <= '0;
		end else if (poll_acc) begin
			for (int k = 0; k < NUM_KEYS; k++) phase_q[k] <= phase_nxt[k];
			seen_q <= '0;
		end else if (rep_acc) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (key_code == 8'(k)) seen_q[k] <= 1'b1;
			end
		end
	end

	ket_axis_smoother #(
		.NUM_KEYS (NUM_KEYS),
		.NUM_AXES (NUM_AXES)
	) u_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (poll_acc),
		.key_down  (key_down),
		.gain      (gain_q),
		.threshold (thr_q),
		.done      (axis_done),
		.axis_lvl  (axis_lvl)
	);

	// Poll sequencing and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (poll_acc) begin
				busy_q <= 1'b1;
			end else if (axis_done) begin
				busy_q <= 1'b0;
			end
			if (axis_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the masks when the poll is taken
	always_ff @(posedge clk) begin
		if (poll_acc) begin
			pressed_q  <= pressed_nxt;
			released_q <= released_nxt;
			down_q     <= down_nxt;
			any_down_q <= |down_nxt;
		end
	end

	assign out_valid               = out_valid_q;
	assign newly_pressed_mask      = pressed_q;
	assign newly_released_mask     = released_q;
	assign down_mask               = down_q;
	assign any_down                = any_down_q;
	assign axis_horizontal         = axis_lvl[0];
	assign axis_vertical           = axis_lvl[1];
	assign axis_horizontal_letters = axis_lvl[2];
	assign axis_vertical_letters   = axis_lvl[3];

	// A result never waits while the axis walk is still running
	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && out_valid_q))
		else $error("result valid during axis update");

	// The axis walk ends only inside a poll
	a_done_in_poll: assert property (@(posedge clk) disable iff (!arst_n)
		axis_done |-> busy_q)
		else $error("axis done outside a poll");

	// A taken poll starts the axis walk
	a_poll_starts: assert property (@(posedge clk) disable iff (!arst_n)
		poll_acc |=> busy_q)
		else $error("poll did not start axis update");

	// The summary flag agrees with the down mask
	a_any_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (any_down_q == (|down_q)))
		else $error("any_down disagrees with down mask");

endmodule

### bench/key_edge_tracker_axis_smoother_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key edge tracker testbench
// Drives key reports and poll ticks through the valid/stall input, programs
// the gain and snap registers over APB between phases, and checks every poll
// result against a local model of the key phases and the smoothed axes.
// ----------------------------------------------------------------------------
module key_edge_tracker_axis_smoother_top_test;
	import ket_pkg::*;

	localparam int NKEYS         = NUM_KEYS_DEF;
	localparam int NAXES         = NUM_AXES_DEF;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 320;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT         = 400000;

	// Item kinds
	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_POLL   = 1'b1;

	// Register settings per phase; the last phase is drawn at random
	localparam int unsigned GAIN_SET [PHASES] = '{255, 0, 1, 128, 200, 0};
	localparam int unsigned THR_SET  [PHASES] = '{0, 164, 0, 16384, 32767, 0};

	localparam logic [7:0] AXIS_EXT    [4] = '{EXT_UP, EXT_DOWN, EXT_LEFT, EXT_RGHT};
	localparam logic [7:0] AXIS_LETTER [4] = '{KEY_W, KEY_A, KEY_S, KEY_D};
	localparam logic [7:0] NAV_EXT [8] = '{EXT_F11, EXT_F12, EXT_INS, EXT_DEL,
		EXT_HOME, EXT_END, EXT_PGUP, EXT_PGDN};
	localparam logic [7:0] SPECIAL_CH [5] = '{CH_ESC, CH_ENTER, CH_SPACE, CH_BKSP, CH_TAB};
	localparam logic [7:0] DIR_EXT [8] = '{EXT_F1, EXT_F10, EXT_UP, EXT_DOWN,
		EXT_LEFT, EXT_RGHT, EXT_F11, EXT_F12};
	localparam logic [7:0] DIR_CH [12] = '{CH_ZERO, CH_NINE, CH_UP_A, CH_LO_Z,
		CH_UP_A + (KEY_D - KEY_A), CH_ESC, CH_ENTER, CH_SPACE, CH_BKSP, CH_TAB,
		8'h00, 8'hFF};
	localparam string AXIS_NAME [4] = '{"axis_horizontal", "axis_vertical",
		"axis_horizontal_letters", "axis_vertical_letters"};

	typedef struct {
		logic             act;
		logic [7:0]       ch;
		logic [7:0]       ext;
		logic [NKEYS-1:0] phys;
	} key_item_t;

	typedef struct {
		logic [NKEYS-1:0]            pressed;
		logic [NKEYS-1:0]            released;
		logic [NKEYS-1:0]            down;
		logic                        any;
		logic [NAXES-1:0][15:0]      lvl;
	} frame_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_stall;
	logic                    action;
	logic [7:0]              raw_char;
	logic [7:0]              extended_code;
	logic [NKEYS-1:0]        physically_down_mask;
	logic                    out_valid;
	logic                    out_stall;
	logic [NKEYS-1:0]        newly_pressed_mask;
	logic [NKEYS-1:0]        newly_released_mask;
	logic [NKEYS-1:0]        down_mask;
	logic                    any_down;
	logic signed [15:0]      axis_horizontal;
	logic signed [15:0]      axis_vertical;
	logic signed [15:0]      axis_horizontal_letters;
	logic signed [15:0]      axis_vertical_letters;

	// Model state
	phase_t             key_ph [NKEYS];
	bit                 seen_q [NKEYS];
	logic signed [15:0] level_q [NAXES];
	logic [7:0]         gain_q;
	logic [14:0]        thr_q;

	key_item_t     pending [$];
	frame_result_t frame_exp [$];
	key_item_t     cur_item;
	bit            item_taken;
	int            idle_pct;
	int            stall_pct;
	int            phase_no;
	int            hold_left;
	bit            hold_done;
	int            fails;
	int            reports_taken;
	int            polls_taken;
	int            results_seen;
	int            cycle_cnt;

	key_edge_tracker_axis_smoother_top i_dut (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.psel                    (psel),
		.penable                 (penable),
		.pwrite                  (pwrite),
		.paddr                   (paddr),
		.pwdata                  (pwdata),
		.prdata                  (prdata),
		.pready                  (pready),
		.in_valid                (in_valid),
		.in_stall                (in_stall),
		.action                  (action),
		.raw_char                (raw_char),
		.extended_code           (extended_code),
		.physically_down_mask    (physically_down_mask),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.newly_pressed_mask      (newly_pressed_mask),
		.newly_released_mask     (newly_released_mask),
		.down_mask               (down_mask),
		.any_down                (any_down),
		.axis_horizontal         (axis_horizontal),
		.axis_vertical           (axis_vertical),
		.axis_horizontal_letters (axis_horizontal_letters),
		.axis_vertical_letters   (axis_vertical_letters)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Map a report to its dense key code, NO_KEY when unknown
	function automatic logic [7:0] key_code(input logic [7:0] ch, input logic [7:0] ext);
		if (ext != 8'd0) begin
			if (ext >= EXT_F1 && ext <= EXT_F10)
				return KEY_F1 + (ext - EXT_F1);
			case (ext)
				EXT_UP:   return KEY_UP;
				EXT_DOWN: return KEY_DOWN;
				EXT_LEFT: return KEY_LEFT;
				EXT_RGHT: return KEY_RIGHT;
				EXT_F11:  return KEY_F11;
				EXT_F12:  return KEY_F12;
				EXT_INS:  return KEY_INS;
				EXT_DEL:  return KEY_DEL;
				EXT_HOME: return KEY_HOME;
				EXT_END:  return KEY_END;
				EXT_PGUP: return KEY_PGUP;
				EXT_PGDN: return KEY_PGDN;
				default:  return NO_KEY;
			endcase
		end
		if (ch >= CH_ZERO && ch <= CH_NINE) return KEY_DIGIT0 + (ch - CH_ZERO);
		if (ch >= CH_UP_A && ch <= CH_UP_Z) return KEY_A + (ch - CH_UP_A);
		if (ch >= CH_LO_A && ch <= CH_LO_Z) return KEY_A + (ch - CH_LO_A);
		case (ch)
			CH_ESC:   return KEY_ESC;
			CH_ENTER: return KEY_ENTER;
			CH_SPACE: return KEY_SPACE;
			CH_BKSP:  return KEY_BKSP;
			CH_TAB:   return KEY_TAB;
			default:  return NO_KEY;
		endcase
	endfunction

	// Move one axis toward its target: rounded exponential step, then snap
	function automatic logic signed [15:0] glide(input logic signed [15:0] lv, input int tgt);
		int diff;
		int mag;
		int stp;
		int nxt;
		diff = tgt - lv;
		mag  = (diff < 0) ? -diff : diff;
		if (gain_q == 8'd0)
			return tgt[15:0];
		stp = (diff * int'(gain_q) + 128) >>> 8;
		nxt = lv + stp;
		if (mag < int'(thr_q))
			nxt = tgt;
		return nxt[15:0];
	endfunction

	// Mark a reported key, or close the frame and queue its result
	task automatic advance_frame(input key_item_t it);
		frame_result_t r;
		phase_t        p;
		logic [7:0]    k;
		int            tgt;
		if (it.act == ACT_REPORT) begin
			k = key_code(it.ch, it.ext);
			if (k < NKEYS)
				seen_q[k] = 1'b1;
		end else begin
			r.pressed  = '0;
			r.released = '0;
			r.down     = '0;
			for (int n = 0; n < NKEYS; n++) begin
				p = key_ph[n];
				if (p == PH_PRESSED)
					p = PH_HELD;
				else if (p == PH_RELEASED)
					p = PH_NONE;
				if (seen_q[n])
					p = (p == PH_NONE) ? PH_PRESSED : PH_HELD;
				else if (p == PH_HELD && !it.phys[n])
					p = PH_RELEASED;
				key_ph[n] = p;
				seen_q[n] = 1'b0;
				r.pressed[n]  = (p == PH_PRESSED);
				r.released[n] = (p == PH_RELEASED);
				r.down[n]     = (p == PH_PRESSED || p == PH_HELD);
			end
			r.any = |r.down;
			for (int a = 0; a < NAXES; a++) begin
				tgt = 0;
				if (r.down[AXIS_POS_KEY[a]]) tgt += LEVEL_POS;
				if (r.down[AXIS_NEG_KEY[a]]) tgt += LEVEL_NEG;
				level_q[a] = glide(level_q[a], tgt);
				r.lvl[a]   = level_q[a];
			end
			frame_exp.insert(frame_exp.size(), r);
		end
	endtask

	function automatic void check_field(input string nm, input logic signed [63:0] e,
			input logic signed [63:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0d (0x%h), actual %0d (0x%h)", nm, e, e, a, a);
			fails++;
		end
	endfunction

	task automatic push_item(input logic act, input logic [7:0] ch, input logic [7:0] ext,
			input logic [NKEYS-1:0] phys);
		key_item_t it;
		it.act  = act;
		it.ch   = ch;
		it.ext  = ext;
		it.phys = phys;
		pending.insert(pending.size(), it);
	endtask

	// Pick a report: mostly known keys with an axis bias, some noise
	task automatic pick_report(output key_item_t it);
		logic [7:0] k;
		it.act  = ACT_REPORT;
		it.ch   = 8'($urandom);
		it.ext  = 8'd0;
		it.phys = NKEYS'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0: it.ext = AXIS_EXT[$urandom_range(0, 3)];
			1, 2: begin
				k = AXIS_LETTER[$urandom_range(0, 3)];
				it.ch = ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + (k - KEY_A);
			end
			3: it.ext = 8'($urandom_range(EXT_F1, EXT_F10));
			4: it.ext = NAV_EXT[$urandom_range(0, 7)];
			5: it.ch = 8'($urandom_range(CH_ZERO, CH_NINE));
			6: it.ch = ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A)
				+ 8'($urandom_range(0, CH_UP_Z - CH_UP_A));
			7: it.ch = SPECIAL_CH[$urandom_range(0, 4)];
			8: ;
			default: it.ext = 8'($urandom_range(1, 255));
		endcase
	endtask

	// Fill one phase with frames: a few reports closed by a poll
	task automatic fill_frames(input int quota);
		key_item_t it;
		int        cnt;
		int        n;
		cnt = 0;
		while (cnt < quota) begin
			n = $urandom_range(0, 5);
			repeat (n) begin
				pick_report(it);
				pending.insert(pending.size(), it);
				cnt++;
			end
			it.act = ACT_POLL;
			it.ch  = 8'($urandom);
			it.ext = 8'($urandom);
			case ($urandom_range(0, 3))
				0: it.phys = NKEYS'({$urandom, $urandom});
				1: it.phys = '1;
				2: it.phys = NKEYS'({$urandom, $urandom} | {$urandom, $urandom});
				default: it.phys = '0;
			endcase
			pending.insert(pending.size(), it);
			cnt++;
		end
	endtask

	task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_GAIN)
			gain_q = data[7:0];
		else
			thr_q = data[14:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input logic idx, input logic [APB_DATA_W-1:0] expv);
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_field((idx == REG_GAIN) ? "smoothing_gain" : "snap_threshold", expv, got);
	endtask

	// Wait until every item is taken and every result has come back
	task automatic settle();
		do @(posedge clk);
		while (pending.size() != 0 || in_valid || frame_exp.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Take an item on the input handshake and update the model
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			advance_frame(cur_item);
			item_taken = 1'b1;
			if (cur_item.act == ACT_POLL)
				polls_taken++;
			else
				reports_taken++;
		end
	end

	// Offer the next pending item, holding the current one until taken
	always @(negedge clk) begin
		if (!in_valid || item_taken) begin
			item_taken = 1'b0;
			if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				cur_item = pending.pop_front();
				in_valid             <= 1'b1;
				action               <= cur_item.act;
				raw_char             <= cur_item.ch;
				extended_code        <= cur_item.ext;
				physically_down_mask <= cur_item.phys;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall results at random; hold off once for a long stretch in phase 1
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (phase_no == 1 && !hold_done && out_valid) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Compare each result item with the oldest expectation
	always @(posedge clk) begin
		frame_result_t          e;
		logic [NAXES-1:0][15:0] got;
		if (arst_n && out_valid && !out_stall) begin
			got = {axis_vertical_letters, axis_horizontal_letters, axis_vertical,
				axis_horizontal};
			if (frame_exp.size() == 0) begin
				$error("result item with no poll waiting for it");
				fails++;
			end else begin
				e = frame_exp.pop_front();
				results_seen++;
				check_field("newly_pressed_mask", e.pressed, newly_pressed_mask);
				check_field("newly_released_mask", e.released, newly_released_mask);
				check_field("down_mask", e.down, down_mask);
				check_field("any_down", e.any, any_down);
				for (int a = 0; a < NAXES; a++)
					check_field(AXIS_NAME[a], $signed(e.lvl[a]), $signed(got[a]));
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("key_edge_tracker_axis_smoother_top verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned g;
		int unsigned t;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		in_valid             = 1'b0;
		action               = ACT_REPORT;
		raw_char             = 8'd0;
		extended_code        = 8'd0;
		physically_down_mask = '0;
		out_stall            = 1'b0;
		item_taken           = 1'b0;
		phase_no             = -1;
		hold_left            = 0;
		hold_done            = 1'b0;
		fails                = 0;
		reports_taken        = 0;
		polls_taken          = 0;
		results_seen         = 0;
		cycle_cnt            = 0;
		idle_pct             = 29;
		stall_pct            = 48;
		gain_q               = GAIN_RST;
		thr_q                = THR_RST;
		for (int n = 0; n < NKEYS; n++) begin
			key_ph[n] = PH_NONE;
			seen_q[n] = 1'b0;
		end
		for (int a = 0; a < NAXES; a++)
			level_q[a] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers come out of reset at their defaults
		check_reg(REG_GAIN, APB_DATA_W'(GAIN_RST));
		check_reg(REG_THR, APB_DATA_W'(THR_RST));
		@(posedge clk);

		// Directed frames: function, arrow and F11/F12 extended codes, every raw group,
		// unknown codes, an unknown extended code overriding a known byte,
		// and polls that press, hold, release and clear
		foreach (DIR_EXT[i])
			push_item(ACT_REPORT, 8'hFF, DIR_EXT[i], '1);
		push_item(ACT_REPORT, CH_LO_A, 8'hFF, '0);
		push_item(ACT_POLL, CH_SPACE, EXT_UP, '0);
		foreach (DIR_CH[i])
			push_item(ACT_REPORT, DIR_CH[i], 8'h00, '1);
		push_item(ACT_POLL, 8'hFF, 8'hFF, '1);
		push_item(ACT_POLL, 8'h00, 8'h00, '0);
		push_item(ACT_POLL, CH_TAB, EXT_F12, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			phase_no = ph;
			case (ph / 2)
				0: begin idle_pct = 29; stall_pct = 48; end
				1: begin idle_pct = 48; stall_pct = 29; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			g = GAIN_SET[ph];
			t = THR_SET[ph];
			if (ph == PHASES - 1) begin
				g = $urandom_range(0, 255);
				t = $urandom_range(0, 32767);
			end
			apb_write(REG_GAIN, APB_DATA_W'(g));
			apb_write(REG_THR, APB_DATA_W'(t));
			check_reg(REG_GAIN, APB_DATA_W'(g));
			check_reg(REG_THR, APB_DATA_W'(t));
			@(posedge clk);
			fill_frames(PHASE_ITEMS);
		end

		settle();
		$display("run covered %0d key reports and %0d polls over %0d register settings",
			reports_taken, polls_taken, PHASES + 1);
		$display("%0d result items checked under three idle patterns and one long hold",
			results_seen);
		if (fails == 0)
			$display("key_edge_tracker_axis_smoother_top verification clean");
		else
			$display("key_edge_tracker_axis_smoother_top verification failed");
		$finish;
	end

endmodule

### sim.f
design/ket_pkg.sv
design/ket_ram.sv
design/ket_axis_smoother.sv
design/key_edge_tracker_axis_smoother_top.sv
bench/key_edge_tracker_axis_smoother_top_test.sv
